// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/fpd_pkg.sv =====
// types, constants and register codes of the flash presence detector
// no dependencies; used by fpd_step and the top level
package fpd_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int STAMP_W     = 32;
  localparam int VOLT_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int BTN_ID_W    = 2;
  localparam int BTN_EV_W    = 2;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_POLL_TICKS     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRY_TICKS    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CHECK_TICKS    = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] HIGH_THRESHOLD_RST = 16'd2000;
  localparam logic [CFG_W-1:0] LOW_THRESHOLD_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = 16'd500;
  localparam logic [CFG_W-1:0] POLL_TICKS_RST     = 16'd100;
  localparam logic [CFG_W-1:0] RETRY_TICKS_RST    = 16'd500;
  localparam logic [CFG_W-1:0] CHECK_TICKS_RST    = 16'd1000;

  // button event codes
  localparam logic [BTN_EV_W-1:0] BTN_NONE    = 2'd0;
  localparam logic [BTN_EV_W-1:0] BTN_PRESS   = 2'd1;
  localparam logic [BTN_EV_W-1:0] BTN_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    MODE_DISC  = 2'd0,
    MODE_DEB   = 2'd1,
    MODE_CONN  = 2'd2,
    MODE_RETRY = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] high_threshold_mv;
    logic [CFG_W-1:0] low_threshold_mv;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] poll_ticks;
    logic [CFG_W-1:0] retry_ticks;
    logic [CFG_W-1:0] check_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  now_ticks;
    logic [VOLT_W-1:0]   voltage_mv;
    logic                nss_active;
    logic                init_ok;
    logic                check_ok;
    logic [BTN_EV_W-1:0] button_event;
    logic [BTN_ID_W-1:0] button_sel;
  } item_t;

  typedef struct packed {
    mode_t                  mode;
    logic [STAMP_W-1:0]     poll_stamp;
    logic [STAMP_W-1:0]     debounce_stamp;
    logic [STAMP_W-1:0]     retry_stamp;
    logic                   detected_bit;
    logic                   valid_bit;
    logic [NUM_BUTTONS-1:0] pressed_bits;
  } state_t;

  typedef struct packed {
    mode_t                  mode_out;
    logic                   mem_detected;
    logic                   flash_valid;
    logic                   nss_flag;
    logic [NUM_BUTTONS-1:0] pressed_mask;
    logic                   init_request;
    logic                   check_request;
    logic                   deinit_request;
  } result_t;

endpackage

// ===== src/fpd_step.sv =====
// next-state and result logic for one sample of the presence detector
// depends on fpd_pkg
module fpd_step
  import fpd_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic                   poll_due;
  logic                   deb_due;
  logic                   retry_due;
  logic                   check_due;
  logic                   present;
  logic                   below_low;
  logic                   check_fail;
  logic                   valid_after;
  logic                   line_drop;
  mode_t                  mode_next;
  logic [NUM_BUTTONS-1:0] btn_bit;
  logic [NUM_BUTTONS-1:0] pressed_next;

  // wrapping elapsed-time compares
  assign poll_due  = (item.now_ticks - st.poll_stamp) >= {16'h0, cfg.poll_ticks};
  assign check_due = (item.now_ticks - st.poll_stamp) >= {16'h0, cfg.check_ticks};
  assign deb_due   = (item.now_ticks - st.debounce_stamp) >= {16'h0, cfg.debounce_ticks};
  assign retry_due = (item.now_ticks - st.retry_stamp) >= {16'h0, cfg.retry_ticks};

  assign present     = !item.nss_active && (item.voltage_mv >= cfg.high_threshold_mv);
  assign below_low   = item.voltage_mv < cfg.low_threshold_mv;
  assign check_fail  = check_due && !item.check_ok;
  assign valid_after = check_due ? item.check_ok : st.valid_bit;
  // line drop is seen with the valid flag as the check left it
  assign line_drop   = valid_after && !item.nss_active && below_low;

  // next state
  always_comb begin
    mode_next = st.mode;
    case (st.mode)
      MODE_DISC: begin
        if (poll_due && present) mode_next = MODE_DEB;
      end
      MODE_DEB: begin
        if (below_low) begin
          mode_next = MODE_DISC;
        end else if (deb_due) begin
          mode_next = item.init_ok ? MODE_CONN : MODE_RETRY;
        end
      end
      MODE_RETRY: begin
        if (retry_due) mode_next = MODE_DISC;
      end
      MODE_CONN: begin
        if (check_fail || line_drop) mode_next = MODE_DISC;
      end
      default: mode_next = MODE_DISC;
    endcase
  end

  // stamps, flags and requests
  always_comb begin
    st_next            = st;
    st_next.mode       = mode_next;
    res.init_request   = 1'b0;
    res.check_request  = 1'b0;
    res.deinit_request = 1'b0;
    case (st.mode)
      MODE_DISC: begin
        if (poll_due) begin
          st_next.poll_stamp = item.now_ticks;
          if (present) st_next.debounce_stamp = item.now_ticks;
        end
      end
      MODE_DEB: begin
        if (!below_low && deb_due) begin
          st_next.detected_bit = 1'b1;
          res.init_request     = 1'b1;
          if (item.init_ok) begin
            st_next.poll_stamp = item.now_ticks;
          end else begin
            st_next.retry_stamp = item.now_ticks;
          end
        end
      end
      MODE_RETRY: begin
      end
      MODE_CONN: begin
        if (check_due) begin
          st_next.poll_stamp = item.now_ticks;
          st_next.valid_bit  = item.check_ok;
          res.check_request  = 1'b1;
          if (!item.check_ok) res.deinit_request = 1'b1;
        end
        if (line_drop) begin
          st_next.detected_bit = 1'b0;
          res.deinit_request   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    st_next.pressed_bits = pressed_next;
    res.mode_out         = mode_next;
    res.mem_detected     = st_next.detected_bit;
    res.flash_valid      = st_next.valid_bit;
    res.nss_flag         = item.nss_active;
    res.pressed_mask     = pressed_next;
  end

  // button mask; ids beyond the button count select no bit
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      btn_bit[i] = (item.button_sel == BTN_ID_W'(i));
    end
  end

  always_comb begin
    case (item.button_event)
      BTN_PRESS:   pressed_next = st.pressed_bits | btn_bit;
      BTN_RELEASE: pressed_next = st.pressed_bits & ~btn_bit;
      default:     pressed_next = st.pressed_bits;
    endcase
  end

endmodule

// ===== src/flash_presence_detect_fsm_top.sv =====
// top level of the flash presence detector: config registers, beat
// registers on both sides and the state registers; uses fpd_pkg, fpd_step
// and the assertion macros in assert_macros.svh
//
//  channel  dir  beat fields (lsb first)
//  s_*      in   now_ticks, voltage_mv, nss_active, init_ok, check_ok,
//                button_event, button_sel
//  m_*      out  mode_out, mem_detected, flash_valid, nss_flag,
//                pressed_mask, init_request, check_request, deinit_request
//  cfg_*    in   register index and 16-bit value, written on cfg_we
//
// one beat per cycle sustained while m_tready stays high; a beat accepted
// is held in the input register, stepped through fpd_step and lands in
// the result register, from which its result shows on m_*
// the state registers update on the same edge as the result register,
// so back-to-back beats see each other's state with no bubble
// a stall on m_tready holds the result; one more beat is still taken
// into the input register, then s_tready drops
// rst is synchronous: mode disconnected, stamps and flags zero,
// registers at their defaults, both beat registers empty
`include "assert_macros.svh"

module flash_presence_detect_fsm_top
  import fpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // sample beat
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now_ticks[31:0], voltage_mv[47:32], nss_active[48], init_ok[49],
  // check_ok[50], button_event[52:51], button_sel[54:53], zero pad[55]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // result beat
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // mode_out[1:0], mem_detected[2], flash_valid[3], nss_flag[4],
  // pressed_mask[7:5], init_request[8], check_request[9],
  // deinit_request[10], zero pad[15:11]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   in_item;
  item_t   s_item;
  logic    in_valid;
  result_t step_res;
  result_t res;
  logic    out_valid;
  logic    advance;

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold_mv <= HIGH_THRESHOLD_RST;
      cfg.low_threshold_mv  <= LOW_THRESHOLD_RST;
      cfg.debounce_ticks    <= DEBOUNCE_TICKS_RST;
      cfg.poll_ticks        <= POLL_TICKS_RST;
      cfg.retry_ticks       <= RETRY_TICKS_RST;
      cfg.check_ticks       <= CHECK_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HIGH_THRESHOLD: cfg.high_threshold_mv <= cfg_data;
        REG_LOW_THRESHOLD:  cfg.low_threshold_mv  <= cfg_data;
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks    <= cfg_data;
        REG_POLL_TICKS:     cfg.poll_ticks        <= cfg_data;
        REG_RETRY_TICKS:    cfg.retry_ticks       <= cfg_data;
        REG_CHECK_TICKS:    cfg.check_ticks       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // unpack the sample beat
  assign s_item.now_ticks    = s_tdata[31:0];
  assign s_item.voltage_mv   = s_tdata[47:32];
  assign s_item.nss_active   = s_tdata[48];
  assign s_item.init_ok      = s_tdata[49];
  assign s_item.check_ok     = s_tdata[50];
  assign s_item.button_event = s_tdata[52:51];
  assign s_item.button_sel   = s_tdata[54:53];

  // the held beat steps when the result register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_item <= s_item;
  end

  fpd_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (step_res)
  );

  // detector state, committed once per stepped beat
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode           <= MODE_DISC;
      st.poll_stamp     <= '0;
      st.debounce_stamp <= '0;
      st.retry_stamp    <= '0;
      st.detected_bit   <= 1'b0;
      st.valid_bit      <= 1'b0;
      st.pressed_bits   <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= step_res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, res.deinit_request, res.check_request, res.init_request,
                     res.pressed_mask, res.nss_flag, res.flash_valid, res.mem_detected,
                     res.mode_out};

  // a teardown always lands in disconnected
  `ASSERT_IMPLIES(a_deinit_disc, clk, rst, out_valid && res.deinit_request,
    res.mode_out == MODE_DISC)
  // an init attempt sets the detected flag and leaves debounce
  `ASSERT_IMPLIES(a_init_detect, clk, rst, out_valid && res.init_request,
    res.mem_detected && (res.mode_out == MODE_CONN || res.mode_out == MODE_RETRY))
  // a passing check leaves the storage marked valid
  `ASSERT_IMPLIES(a_check_valid, clk, rst,
    out_valid && res.check_request && !res.deinit_request, res.flash_valid)
  // state moves only when a beat steps
  `ASSERT_NEXT(a_state_hold, clk, rst, !advance, $stable(st))

endmodule
